// File: src/arxbcm_pkg.sv
`timescale 1ns / 1ps
// Package for the ARX block cipher mode encryptor: register indexes, mode codes,
// cipher constants and the shared rotate and mixing functions. No dependencies.
package arxbcm_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_CIPHER  = 3'd0;
    localparam logic [2:0] REG_MODE    = 3'd1;
    localparam logic [2:0] REG_KEY_LO  = 3'd2;
    localparam logic [2:0] REG_KEY_HI  = 3'd3;
    localparam logic [2:0] REG_IV_LO   = 3'd4;
    localparam logic [2:0] REG_IV_HI   = 3'd5;

    // Chaining mode codes; the spare code behaves as ECB
    localparam logic [2:0] MODE_ECB   = 3'd0;
    localparam logic [2:0] MODE_CBC   = 3'd1;
    localparam logic [2:0] MODE_PCBC  = 3'd2;
    localparam logic [2:0] MODE_CFB   = 3'd3;
    localparam logic [2:0] MODE_OFB   = 3'd4;
    localparam logic [2:0] MODE_CTR   = 3'd5;
    localparam logic [2:0] MODE_RDC   = 3'd6;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    // Round key store and schedule
    localparam int RK_DEPTH   = 40;
    localparam int RK_AW      = 6;
    localparam int KEYS_C0    = 36;
    localparam int KEYS_C1    = 40;
    localparam int ENC_STEPS  = 40;
    localparam int TAIL_START = 36;
    localparam logic [RK_AW-1:0] TAIL_BASE_C0 = 6'd32;
    localparam logic [RK_AW-1:0] TAIL_BASE_C1 = 6'd36;

    // Key schedule constants (key length of 16 bytes folded into the seed)
    localparam logic [31:0] SEED_C0  = 32'h54465748 ^ 32'h10101010;
    localparam logic [31:0] SEED_C1  = 32'h4D415253 ^ 32'h10101010;
    localparam logic [31:0] KS_GOLD  = 32'h9E3779B9;
    localparam logic [31:0] KS_ALT   = 32'hA5A5A5A5;
    localparam logic [31:0] KS_TWEAK = 32'h3C6EF372;

    // Round function constants
    localparam logic [31:0] G_MUL = 32'h9E3779B1;
    localparam logic [31:0] G_ADD = 32'h7F4A7C15;
    localparam logic [31:0] G_XAD = 32'hA5A5A5A5;
    localparam logic [31:0] H_ADD = 32'hA4A8D57B;
    localparam logic [31:0] H_XOR = 32'h3C6EF372;

    function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} >> s;
        return t[31:0];
    endfunction

    function automatic logic [31:0] mix_g(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] a;
        logic [31:0] p;
        logic [31:0] b;
        a = x ^ k;
        p = a * G_MUL;
        b = rol32(p + G_ADD, k[31:27] + 5'd1);
        return b ^ ror32(b + G_XAD, 5'd7);
    endfunction

    function automatic logic [31:0] mix_h(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] z;
        z = rol32(x ^ (y + H_ADD), x[31:27] + 5'd1);
        return (z + ror32(y ^ H_XOR, 5'd11)) ^ rol32(z, 5'd7);
    endfunction

    // Odd-forced delta: each byte from IV, key and a position constant
    function automatic logic [127:0] make_delta(input logic [127:0] iv,
                                                 input logic [127:0] key);
        logic [127:0] r;
        logic [7:0]   v;
        for (int i = 0; i < 16; i++) begin
            v = iv[8*i +: 8] ^ key[8*i +: 8] ^ 8'(i * 19 + 1);
            r[8*i +: 8] = v | 8'd1;
        end
        return r;
    endfunction

endpackage

// File: src/arxbcm_ram.sv
`timescale 1ns / 1ps
// Generic single write, single read RAM with registered read data.
// No dependencies.
module arxbcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/arx_block_cipher_mode_encryptor_unit.sv
`timescale 1ns / 1ps
// Top level of the ARX block cipher mode encryptor.
// Depends on arxbcm_pkg and arxbcm_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one 128-bit plaintext request
//   as block_low/block_high plus first_block. Output channel
//   (out_valid/out_ready) returns one 128-bit ciphertext per request.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while the block is idle.
// Processing:
//   One shared round step unit handles one quarter round (one round key) per
//   cycle; a request passes a load state, 40 encryption steps (one round key
//   read each) and a result state, preceded by a key schedule of 36 or 40 key
//   words (one key word per cycle) when first_block is set.
//   The block takes one request at a time; in_ready stays low until the result state is done.
// Reset:
//   Control registers, chain, counter and delta clear; round keys are undefined until
//   a first block derives them.
// Stall:
//   A finished result waits in the output register; if the previous result is
//   still held, the new one waits in the result state until it is taken.
module arx_block_cipher_mode_encryptor_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    input  logic        first_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_low,
    output logic [63:0] out_high,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_KEYGEN = 3'd1;
    localparam logic [2:0] ST_PRE    = 3'd2;
    localparam logic [2:0] ST_ENC    = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    localparam int AW = arxbcm_pkg::RK_AW;

    logic [2:0]    state_reg, state_next;
    logic          cipher_reg, cipher_next;
    logic [2:0]    mode_reg, mode_next;
    logic [127:0]  key_reg, key_next;
    logic [127:0]  iv_reg, iv_next;
    logic [127:0]  chain_reg, chain_next;
    logic [127:0]  counter_reg, counter_next;
    logic [127:0]  delta_reg, delta_next;
    logic [127:0]  plain_reg, plain_next;
    logic [31:0]   w_reg [4];
    logic [31:0]   w_next [4];
    logic [AW-1:0] step_reg, step_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   gold_reg, gold_next;
    logic [31:0]   alt_reg, alt_next;
    logic [31:0]   tweak_reg, tweak_next;
    logic [4:0]    rot7_reg, rot7_next;
    logic [4:0]    rot5_reg, rot5_next;
    logic [127:0]  out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          rk_we;
    logic [AW-1:0] rk_raddr;
    logic [31:0]   rk_wdata;
    logic [31:0]   rk;

    logic [31:0]   ks_word, ks_mix, ks_acc;
    logic [AW-1:0] step_inc;
    logic [AW-1:0] tail_base;
    logic [127:0]  enc_res;
    logic [127:0]  src_blk;
    logic [31:0]   g_x, g_res;
    logic [31:0]   h_x, h_y, h_res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_low   = out_reg[63:0];
    assign out_high  = out_reg[127:64];
    assign enc_res   = {w_reg[3], w_reg[2], w_reg[1], w_reg[0]};

    // Round key store
    arxbcm_ram #(
        .WIDTH (32),
        .DEPTH (arxbcm_pkg::RK_DEPTH)
    ) u_rk_ram (
        .clk   (clk),
        .we    (rk_we),
        .waddr (step_reg),
        .wdata (rk_wdata),
        .raddr (rk_raddr),
        .rdata (rk)
    );

    // Key schedule step: one round key per cycle
    always_comb
    begin
        ks_word  = key_reg[32*step_reg[1:0] +: 32];
        ks_mix   = arxbcm_pkg::rol32(ks_word + gold_reg + acc_reg, rot7_reg);
        ks_acc   = arxbcm_pkg::rol32(acc_reg ^ ks_mix ^ alt_reg, rot5_reg);
        rk_wdata = ks_mix ^ ks_acc ^ tweak_reg;
        rk_we    = (state_reg == ST_KEYGEN);
    end

    // Prefetch address of the key for the following step
    always_comb
    begin
        step_inc  = step_reg + 1'b1;
        tail_base = cipher_reg ? arxbcm_pkg::TAIL_BASE_C1 : arxbcm_pkg::TAIL_BASE_C0;
        if (state_reg != ST_ENC)
        begin
            rk_raddr = '0;
        end
        else if (step_inc == AW'(arxbcm_pkg::ENC_STEPS))
        begin
            rk_raddr = '0;
        end
        else if (step_inc >= AW'(arxbcm_pkg::TAIL_START))
        begin
            rk_raddr = step_inc - AW'(arxbcm_pkg::TAIL_START) + tail_base;
        end
        else
        begin
            rk_raddr = step_inc;
        end
    end

    // Shared mixing units: pick the operands of this quarter round
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                g_x = w_reg[3];
                h_x = w_reg[0] + rk;
                h_y = w_reg[1];
            end
            2'd1:
            begin
                g_x = w_reg[0];
                h_x = w_reg[2] ^ rk;
                h_y = w_reg[3];
            end
            2'd2:
            begin
                g_x = w_reg[1];
                h_x = w_reg[3];
                h_y = rk;
            end
            default:
            begin
                g_x = w_reg[2];
                h_x = w_reg[1];
                h_y = rk;
            end
        endcase
        g_res = arxbcm_pkg::mix_g(g_x, rk);
        h_res = arxbcm_pkg::mix_h(h_x, h_y);
    end

    // Cipher input selected by chaining mode
    always_comb
    begin
        case (mode_reg)
            arxbcm_pkg::MODE_CBC, arxbcm_pkg::MODE_PCBC: src_blk = plain_reg ^ chain_reg;
            arxbcm_pkg::MODE_CFB, arxbcm_pkg::MODE_OFB:  src_blk = chain_reg;
            arxbcm_pkg::MODE_CTR, arxbcm_pkg::MODE_RDC:  src_blk = counter_reg;
            default:                                     src_blk = plain_reg;
        endcase
    end

    // Sequencer and shared step unit
    always_comb
    begin
        state_next     = state_reg;
        cipher_next    = cipher_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        iv_next        = iv_reg;
        chain_next     = chain_reg;
        counter_next   = counter_reg;
        delta_next     = delta_reg;
        plain_next     = plain_reg;
        w_next         = w_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        gold_next      = gold_reg;
        alt_next       = alt_reg;
        tweak_next     = tweak_reg;
        rot7_next      = rot7_reg;
        rot5_next      = rot5_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                arxbcm_pkg::REG_CIPHER: cipher_next      = cfg_data[0];
                arxbcm_pkg::REG_MODE:   mode_next        = cfg_data[2:0];
                arxbcm_pkg::REG_KEY_LO: key_next[63:0]   = cfg_data;
                arxbcm_pkg::REG_KEY_HI: key_next[127:64] = cfg_data;
                arxbcm_pkg::REG_IV_LO:  iv_next[63:0]    = cfg_data;
                arxbcm_pkg::REG_IV_HI:  iv_next[127:64]  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    plain_next = {block_high, block_low};
                    step_next  = '0;
                    if (first_block)
                    begin
                        delta_next   = arxbcm_pkg::make_delta(iv_reg, key_reg);
                        chain_next   = iv_reg;
                        counter_next = iv_reg;
                        acc_next     = cipher_reg ? arxbcm_pkg::SEED_C1
                                                  : arxbcm_pkg::SEED_C0;
                        gold_next    = arxbcm_pkg::KS_GOLD;
                        alt_next     = '0;
                        tweak_next   = arxbcm_pkg::KS_TWEAK;
                        rot7_next    = '0;
                        rot5_next    = 5'd3;
                        state_next   = ST_KEYGEN;
                    end
                    else
                    begin
                        state_next = ST_PRE;
                    end
                end
            end

            ST_KEYGEN:
            begin
                acc_next   = ks_acc;
                gold_next  = gold_reg + arxbcm_pkg::KS_GOLD;
                alt_next   = alt_reg + arxbcm_pkg::KS_ALT;
                tweak_next = tweak_reg + arxbcm_pkg::KS_TWEAK;
                rot7_next  = rot7_reg + 5'd7;
                rot5_next  = rot5_reg + 5'd5;
                step_next  = step_inc;
                if (step_reg == (cipher_reg ? AW'(arxbcm_pkg::KEYS_C1 - 1)
                                            : AW'(arxbcm_pkg::KEYS_C0 - 1)))
                begin
                    step_next  = '0;
                    state_next = ST_PRE;
                end
            end

            ST_PRE:
            begin
                // Load cipher input; key 0 read is under way
                w_next[0]  = src_blk[31:0];
                w_next[1]  = src_blk[63:32];
                w_next[2]  = src_blk[95:64];
                w_next[3]  = src_blk[127:96];
                step_next  = '0;
                state_next = ST_ENC;
            end

            ST_ENC:
            begin
                if (step_reg < 6'd4)
                begin
                    // Input whitening
                    if (cipher_reg)
                        w_next[step_reg[1:0]] = w_reg[step_reg[1:0]] + rk;
                    else
                        w_next[step_reg[1:0]] = w_reg[step_reg[1:0]] ^ rk;
                end
                else if (step_reg >= AW'(arxbcm_pkg::TAIL_START))
                begin
                    // Output whitening
                    w_next[step_reg[1:0]] = w_reg[step_reg[1:0]] ^ rk;
                end
                else if (!cipher_reg)
                begin
                    case (step_reg[1:0])
                        2'd0: w_next[0] = arxbcm_pkg::rol32(w_reg[0] + g_res, 5'd1);
                        2'd1: w_next[1] = arxbcm_pkg::rol32(w_reg[1] ^ g_res, 5'd3);
                        2'd2: w_next[2] = arxbcm_pkg::rol32(w_reg[2] + g_res, 5'd6);
                        default:
                        begin
                            // Last quarter, then swap a with b and c with d
                            w_next[0] = w_reg[1];
                            w_next[1] = w_reg[0];
                            w_next[2] = arxbcm_pkg::rol32(w_reg[3] ^ g_res, 5'd11);
                            w_next[3] = w_reg[2];
                        end
                    endcase
                end
                else
                begin
                    case (step_reg[1:0])
                        2'd0: w_next[1] = arxbcm_pkg::rol32(w_reg[1] ^ h_res, 5'd5);
                        2'd1: w_next[3] = arxbcm_pkg::rol32(w_reg[3] + h_res, 5'd9);
                        2'd2: w_next[0] = arxbcm_pkg::rol32(w_reg[0] + h_res, 5'd13);
                        default:
                        begin
                            // Last quarter, then rotate the words left by one
                            w_next[0] = w_reg[1];
                            w_next[1] = arxbcm_pkg::rol32(w_reg[2] ^ h_res, 5'd17);
                            w_next[2] = w_reg[3];
                            w_next[3] = w_reg[0];
                        end
                    endcase
                end
                step_next = step_inc;
                if (step_reg == AW'(arxbcm_pkg::ENC_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT:
            begin
                // Hold until the output register is free, then update chaining state
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    case (mode_reg)
                        arxbcm_pkg::MODE_CBC:
                        begin
                            out_next   = enc_res;
                            chain_next = enc_res;
                        end
                        arxbcm_pkg::MODE_PCBC:
                        begin
                            out_next   = enc_res;
                            chain_next = plain_reg ^ enc_res;
                        end
                        arxbcm_pkg::MODE_CFB:
                        begin
                            out_next   = plain_reg ^ enc_res;
                            chain_next = plain_reg ^ enc_res;
                        end
                        arxbcm_pkg::MODE_OFB:
                        begin
                            out_next   = plain_reg ^ enc_res;
                            chain_next = enc_res;
                        end
                        arxbcm_pkg::MODE_CTR:
                        begin
                            out_next            = plain_reg ^ enc_res;
                            counter_next[7:0]   = counter_reg[7:0] + 8'd1;
                        end
                        arxbcm_pkg::MODE_RDC:
                        begin
                            out_next     = plain_reg ^ enc_res;
                            counter_next = counter_reg + delta_reg;
                        end
                        default:
                        begin
                            out_next = enc_res;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cipher_reg    <= 1'b0;
            mode_reg      <= arxbcm_pkg::MODE_ECB;
            key_reg       <= '0;
            iv_reg        <= '0;
            chain_reg     <= '0;
            counter_reg   <= '0;
            delta_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cipher_reg    <= cipher_next;
            mode_reg      <= mode_next;
            key_reg       <= key_next;
            iv_reg        <= iv_next;
            chain_reg     <= chain_next;
            counter_reg   <= counter_next;
            delta_reg     <= delta_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        plain_reg <= plain_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        gold_reg  <= gold_next;
        alt_reg   <= alt_next;
        tweak_reg <= tweak_next;
        rot7_reg  <= rot7_next;
        rot5_reg  <= rot5_next;
        out_reg   <= out_next;
    end

endmodule

// File: src/arxbcm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the ARX block cipher mode encryptor, bound to the top level.
// Depends on arx_block_cipher_mode_encryptor_unit.
module arxbcm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cfg_ready
);

    // A result waiting on the receiver stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // One request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // A new result is only raised as the block finishes a request
    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result raised without a request in flight");

    // Configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind arx_block_cipher_mode_encryptor_unit arxbcm_checker u_arxbcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_ready (cfg_ready)
);

// File: tb/sv/arx_block_cipher_mode_encryptor_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the ARX block cipher mode encryptor: directed table, then random
// messages over all ciphers and chaining modes, checked against an in-bench cipher model.
// Depends on arxbcm_pkg and the arx_block_cipher_mode_encryptor_unit RTL.
module arx_block_cipher_mode_encryptor_unit_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PHASES  = 24;
    localparam int PHASE_BLOCKS   = 66;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        first_block;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] out_low;
    logic [63:0] out_high;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    arx_block_cipher_mode_encryptor_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .block_low  (block_low),
        .block_high (block_high),
        .first_block(first_block),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_low    (out_low),
        .out_high   (out_high),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Shadow configuration and chaining state
    logic         sh_cipher;
    logic [2:0]   sh_mode;
    logic [127:0] sh_key;
    logic [127:0] sh_iv;
    logic [127:0] sh_chain;
    logic [127:0] sh_counter;
    logic [127:0] sh_delta;
    logic [31:0]  sched[arxbcm_pkg::RK_DEPTH];

    logic [127:0] ciphertext_q[$];
    int           mismatches;
    int           blocks_sent;
    int           blocks_checked;
    int           quiet_cycles;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    int           gen_keys_filled;
    logic         gen_cipher;

    typedef struct {
        logic        cipher;
        logic [2:0]  mode;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        first;
    } block_row_t;

    block_row_t directed_rows[] = '{
        '{1'b0, arxbcm_pkg::MODE_ECB,  64'h0, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_ECB,  '1, '1, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_ECB,  64'h8000_0000_0000_0001, 64'h0000_0001_8000_0000, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_CBC,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_CBC,  64'h0, '1, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_PCBC, '1, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_PCBC, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_CFB,  64'h0, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_CFB,  '1, '1, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_OFB,  64'h0, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_OFB,  64'h0, 64'h0, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_CTR,  64'h0, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_CTR,  64'h0, 64'h0, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_CTR,  '1, '1, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_RDC,  64'h0, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_RDC,  64'h0, 64'h0, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_RDC,  '1, 64'h0, 1'b0},
        '{1'b0, arxbcm_pkg::MODE_SPARE, 64'h0, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_SPARE, '1, '1, 1'b0},
        '{1'b1, arxbcm_pkg::MODE_ECB,  64'h0, 64'h0, 1'b1},
        '{1'b1, arxbcm_pkg::MODE_CBC,  '1, '1, 1'b0},
        '{1'b1, arxbcm_pkg::MODE_RDC,  64'h1, 64'h0, 1'b1},
        '{1'b0, arxbcm_pkg::MODE_CBC,  64'h0, 64'h0, 1'b0},
        '{1'b1, arxbcm_pkg::MODE_CBC,  64'hDEAD_BEEF_0000_FFFF, 64'h1, 1'b0}
    };

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        s = s % 32;
        return (s == 0) ? v : ((v << s) | (v >> (32 - s)));
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        s = s % 32;
        return (s == 0) ? v : ((v >> s) | (v << (32 - s)));
    endfunction

    function automatic logic [31:0] g_mix(input logic [31:0] x, input logic [31:0] k);
        logic [31:0] b;
        b = rotl((x ^ k) * arxbcm_pkg::G_MUL + arxbcm_pkg::G_ADD, int'(k[31:27]) + 1);
        return b ^ rotr(b + arxbcm_pkg::G_XAD, 7);
    endfunction

    function automatic logic [31:0] h_mix(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] z;
        z = rotl(x ^ (y + arxbcm_pkg::H_ADD), int'(x[31:27]) + 1);
        return (z + rotr(y ^ arxbcm_pkg::H_XOR, 11)) ^ rotl(z, 7);
    endfunction

    // Expand the key into the round key schedule
    task automatic expand_key(input int count, input logic [31:0] seed);
        logic [31:0] acc;
        logic [31:0] mix;
        logic [31:0] n;
        acc = seed ^ 32'h1010_1010;
        for (int i = 0; i < count; i++) begin
            n   = i + 1;
            mix = rotl(sh_key[32*(i%4) +: 32] + arxbcm_pkg::KS_GOLD * n + acc, (i * 7) % 32);
            acc = rotl(acc ^ mix ^ (arxbcm_pkg::KS_ALT * i), (i * 5 + 3) % 32);
            sched[i] = mix ^ acc ^ (arxbcm_pkg::KS_TWEAK * n);
        end
    endtask

    function automatic logic [127:0] encipher(input logic [127:0] blk);
        logic [31:0] a, b, c, d, t, e, f;
        int tail;
        a = blk[31:0]; b = blk[63:32]; c = blk[95:64]; d = blk[127:96];
        if (!sh_cipher) begin
            a ^= sched[0]; b ^= sched[1]; c ^= sched[2]; d ^= sched[3];
            for (int r = 0; r < 8; r++) begin
                a = rotl(a + g_mix(d, sched[4+4*r]), 1);
                b = rotl(b ^ g_mix(a, sched[5+4*r]), 3);
                c = rotl(c + g_mix(b, sched[6+4*r]), 6);
                d = rotl(d ^ g_mix(c, sched[7+4*r]), 11);
                t = a; a = b; b = t;
                t = c; c = d; d = t;
            end
            tail = 36;
        end else begin
            a += sched[0]; b += sched[1]; c += sched[2]; d += sched[3];
            for (int r = 0; r < 8; r++) begin
                e = h_mix(a + sched[4+4*r], b);
                f = h_mix(c ^ sched[5+4*r], d);
                b = rotl(b ^ e, 5);
                d = rotl(d + f, 9);
                a = rotl(a + h_mix(d, sched[6+4*r]), 13);
                c = rotl(c ^ h_mix(b, sched[7+4*r]), 17);
                t = a; a = b; b = c; c = d; d = t;
            end
            tail = 40;
        end
        return {d ^ sched[tail-1], c ^ sched[tail-2], b ^ sched[tail-3], a ^ sched[tail-4]};
    endfunction

    // Work out the ciphertext for one accepted request and advance the chain
    task automatic predict_ciphertext(input logic [127:0] pt, input logic first);
        logic [127:0] res;
        logic [127:0] ks;
        logic [7:0]   v;
        if (first) begin
            if (!sh_cipher) expand_key(arxbcm_pkg::KEYS_C0, 32'h5446_5748);
            else            expand_key(arxbcm_pkg::KEYS_C1, 32'h4D41_5253);
            for (int n = 0; n < 16; n++) begin
                v = sh_iv[8*n +: 8] ^ sh_key[8*n +: 8] ^ 8'((n * 19 + 1) & 8'hFF);
                sh_delta[8*n +: 8] = v | 8'd1;
            end
            sh_chain   = sh_iv;
            sh_counter = sh_iv;
        end
        case (sh_mode)
            arxbcm_pkg::MODE_CBC: begin
                res = encipher(pt ^ sh_chain);
                sh_chain = res;
            end
            arxbcm_pkg::MODE_PCBC: begin
                res = encipher(pt ^ sh_chain);
                sh_chain = pt ^ res;
            end
            arxbcm_pkg::MODE_CFB: begin
                res = pt ^ encipher(sh_chain);
                sh_chain = res;
            end
            arxbcm_pkg::MODE_OFB: begin
                ks = encipher(sh_chain);
                sh_chain = ks;
                res = pt ^ ks;
            end
            arxbcm_pkg::MODE_CTR: begin
                res = pt ^ encipher(sh_counter);
                sh_counter[7:0] = sh_counter[7:0] + 8'd1;
            end
            arxbcm_pkg::MODE_RDC: begin
                res = pt ^ encipher(sh_counter);
                sh_counter = sh_counter + sh_delta;
            end
            default: res = encipher(pt);
        endcase
        ciphertext_q.push_back(res);
    endtask

    // Observe every handshake at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    arxbcm_pkg::REG_CIPHER: sh_cipher <= cfg_data[0];
                    arxbcm_pkg::REG_MODE:   sh_mode <= cfg_data[2:0];
                    arxbcm_pkg::REG_KEY_LO: sh_key[63:0] <= cfg_data;
                    arxbcm_pkg::REG_KEY_HI: sh_key[127:64] <= cfg_data;
                    arxbcm_pkg::REG_IV_LO:  sh_iv[63:0] <= cfg_data;
                    arxbcm_pkg::REG_IV_HI:  sh_iv[127:64] <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_ciphertext({block_high, block_low}, first_block);
            if (out_valid && out_ready) begin
                blocks_checked++;
                if (ciphertext_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected ciphertext %h_%h", out_high, out_low);
                end else begin
                    if ({out_high, out_low} !== ciphertext_q[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ciphertext mismatch: expected %h_%h got %h_%h",
                                     ciphertext_q[0][127:64], ciphertext_q[0][63:0],
                                     out_high, out_low);
                    end
                    void'(ciphertext_q.pop_front());
                end
            end
        end
    end

    // Watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d ciphertexts outstanding",
                     ciphertext_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Present one request, with a random gap ahead of it
    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi, input logic first);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        block_low   <= lo;
        block_high  <= hi;
        first_block <= first;
        do @(posedge clk); while (!in_ready);
        blocks_sent++;
        if (first)
            gen_keys_filled = (gen_cipher || gen_keys_filled == arxbcm_pkg::KEYS_C1)
                              ? arxbcm_pkg::KEYS_C1 : arxbcm_pkg::KEYS_C0;
    endtask

    // Hold until every ciphertext is back and the block has settled
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (ciphertext_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_word;
        case ($urandom_range(7, 0))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    int          n_blocks;
    logic        first;
    logic [2:0]  mode;
    logic [63:0] iv_lo;

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0; block_low = '0; block_high = '0; first_block = 1'b0;
        out_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        sh_cipher = 1'b0; sh_mode = '0; sh_key = '0; sh_iv = '0;
        sh_chain = '0; sh_counter = '0; sh_delta = '0;
        foreach (sched[i]) sched[i] = '0;
        mismatches = 0; blocks_sent = 0; blocks_checked = 0; quiet_cycles = 0;
        sender_idle_pct = 0; receiver_stall_pct = 0;
        gen_keys_filled = 0; gen_cipher = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table: key and IV chosen so the byte counter wraps and the delta carries
        write_reg(arxbcm_pkg::REG_KEY_LO, '1);
        write_reg(arxbcm_pkg::REG_KEY_HI, 64'h0);
        write_reg(arxbcm_pkg::REG_IV_LO, 64'hFFFF_FFFF_FFFF_FFFE);
        write_reg(arxbcm_pkg::REG_IV_HI, '1);
        write_reg(arxbcm_pkg::REG_CIPHER, 64'h0);
        write_reg(arxbcm_pkg::REG_MODE, 64'(arxbcm_pkg::MODE_ECB));
        foreach (directed_rows[i]) begin
            if (directed_rows[i].cipher != gen_cipher || directed_rows[i].mode != mode
                || i == 0) begin
                drain();
                write_reg(arxbcm_pkg::REG_CIPHER, 64'(directed_rows[i].cipher));
                write_reg(arxbcm_pkg::REG_MODE, 64'(directed_rows[i].mode));
                gen_cipher = directed_rows[i].cipher;
                mode = directed_rows[i].mode;
            end
            send_block(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].first);
        end

        // Random messages, one configuration per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 63; end
                default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
            endcase
            gen_cipher = 1'($urandom_range(1, 0));
            mode  = (ph < 16) ? 3'(ph % 8) : 3'($urandom_range(7, 0));
            iv_lo = (ph == 0) ? 64'h0 : (ph == 1) ? '1 : pick_word();
            if (ph % 3 == 2) iv_lo[7:0] = 8'hE0 | 8'($urandom_range(31, 0));
            write_reg(arxbcm_pkg::REG_CIPHER, 64'(gen_cipher));
            write_reg(arxbcm_pkg::REG_MODE, 64'(mode));
            write_reg(arxbcm_pkg::REG_KEY_LO,
                      (ph == 0) ? 64'h0 : (ph == 1) ? '1 : pick_word());
            write_reg(arxbcm_pkg::REG_KEY_HI,
                      (ph == 0) ? 64'h0 : (ph == 1) ? '1 : pick_word());
            write_reg(arxbcm_pkg::REG_IV_LO, iv_lo);
            write_reg(arxbcm_pkg::REG_IV_HI,
                      (ph == 0) ? 64'h0 : (ph == 1) ? '1 : pick_word());
            n_blocks = PHASE_BLOCKS;
            for (int k = 0; k < n_blocks; k++) begin
                // a fresh message whenever the stored keys do not cover this cipher
                first = (k == 0) || ($urandom_range(11, 0) == 0)
                        || (gen_cipher && gen_keys_filled < arxbcm_pkg::KEYS_C1);
                send_block(pick_word(), pick_word(), first);
            end
        end
        drain();

        $display("%0d blocks sent, %0d ciphertexts checked, %0d mismatches",
                 blocks_sent, blocks_checked, mismatches);
        $display("covered both ciphers, all eight mode codes, key and IV extremes, stalls");
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
